/* src/tcpct_pkg.sv */
// Package with the connection phase type and TCP flag constants for the tracker.
`default_nettype none

package tcpct_pkg;

    // Connection phase; the code 7 is never produced and reads as failure.
    typedef enum logic [2:0] {
        PH_LISTEN  = 3'd0,
        PH_REQ     = 3'd1,
        PH_EST     = 3'd2,
        PH_DATA    = 3'd3,
        PH_CLOSING = 3'd4,
        PH_CLOSED  = 3'd5,
        PH_FAIL    = 3'd6
    } phase_t;

    // TCP flag bits that the tracker examines.
    localparam logic [7:0] FLAG_FIN     = 8'h01;
    localparam logic [7:0] FLAG_SYN     = 8'h02;
    localparam logic [7:0] FLAG_RST     = 8'h04;
    localparam logic [7:0] FLAG_ACK     = 8'h10;
    localparam logic [7:0] FLAG_TRACKED = FLAG_FIN | FLAG_SYN | FLAG_RST | FLAG_ACK;

    // Masked flag combinations used by the transition rules.
    localparam logic [7:0] F_SYNACK = FLAG_SYN | FLAG_ACK;
    localparam logic [7:0] F_RSTACK = FLAG_RST | FLAG_ACK;
    localparam logic [7:0] F_FINACK = FLAG_FIN | FLAG_ACK;

endpackage

`default_nettype wire

/* src/tcp_connection_tracker_unit.sv */
// Passive single-connection TCP tracker: input register, state update, result register.
`default_nettype none

// The tracker watches one TCP connection and takes one observed segment per request.
// A request is held in an input register; when the result register is free, one pass
// of combinational logic (the phase rules and a single 64-bit byte counter add) updates
// the connection state and loads the result register in the same clock edge. A segment
// passes through the input register and then the result register, and one segment can be
// accepted in every cycle as long as results are taken. The result carries the accept
// flag, the phase after the update, both byte counters and the time of the last counted
// segment. Once the failure phase is reached it holds until reset.
module tcp_connection_tracker_unit
    import tcpct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        pkt_dir,
    input  wire logic [7:0]  tcp_flags,
    input  wire logic [15:0] seg_size,
    input  wire logic [63:0] time_now,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             accepted,
    output logic [2:0]       conn_state,
    output logic [63:0]      bytes_dir0,
    output logic [63:0]      bytes_dir1,
    output logic [63:0]      last_time
);

    // Input register
    logic        in_valid_reg;
    logic        dir_reg;
    logic [7:0]  flags_reg;
    logic [15:0] size_reg;
    logic [63:0] now_reg;

    // Connection state
    phase_t      phase_reg, phase_next;
    logic        opener_reg, opener_next;
    logic        closer_reg, closer_next;
    logic [63:0] cnt0_reg, cnt0_next;
    logic [63:0] cnt1_reg, cnt1_next;
    logic [63:0] last_reg, last_next;

    // Result register
    logic        out_valid_reg;
    logic        res_ok_reg;
    logic [2:0]  res_state_reg;
    logic [63:0] res_cnt0_reg;
    logic [63:0] res_cnt1_reg;
    logic [63:0] res_last_reg;

    // Handshake and pipeline movement.
    logic        advance;
    logic        ok;
    logic        do_count;
    logic        do_open;
    logic [7:0]  f;
    logic        from_opener;
    logic        is_rst;
    logic        is_fin;
    logic [63:0] cnt_sel;
    logic [63:0] cnt_sum;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dir_reg   <= pkt_dir;
            flags_reg <= tcp_flags;
            size_reg  <= seg_size;
            now_reg   <= time_now;
        end
    end

    // Flag decode.
    assign f           = flags_reg & FLAG_TRACKED;
    assign from_opener = (dir_reg == opener_reg);
    assign is_rst      = (f == FLAG_RST) || (f == F_RSTACK);
    assign is_fin      = (f == FLAG_FIN) || (f == F_FINACK);

    // Phase rules for one segment.
    always_comb
    begin
        ok          = 1'b0;
        do_count    = 1'b0;
        do_open     = 1'b0;
        phase_next  = PH_FAIL;
        closer_next = closer_reg;
        unique case (phase_reg)
            PH_LISTEN:
            begin
                if (f == FLAG_SYN)
                begin
                    ok         = 1'b1;
                    do_open    = 1'b1;
                    phase_next = PH_REQ;
                end
            end
            PH_REQ:
            begin
                if (f == F_SYNACK)
                begin
                    if (!from_opener)
                    begin
                        ok         = 1'b1;
                        do_count   = 1'b1;
                        phase_next = PH_EST;
                    end
                end
                else if (f == FLAG_SYN || f == FLAG_ACK)
                begin
                    if (from_opener)
                    begin
                        ok         = 1'b1;
                        phase_next = PH_REQ;
                    end
                end
                else if (is_rst)
                begin
                    ok          = 1'b1;
                    do_count    = 1'b1;
                    phase_next  = PH_CLOSED;
                    closer_next = dir_reg;
                end
            end
            PH_EST:
            begin
                if (f == FLAG_ACK)
                begin
                    if (from_opener)
                    begin
                        ok         = 1'b1;
                        do_count   = 1'b1;
                        phase_next = PH_DATA;
                    end
                end
                else if (f == FLAG_SYN)
                begin
                    if (from_opener)
                    begin
                        ok         = 1'b1;
                        phase_next = PH_EST;
                    end
                end
                else if (f == F_SYNACK)
                begin
                    if (!from_opener)
                    begin
                        ok         = 1'b1;
                        phase_next = PH_EST;
                    end
                end
                else if (is_rst)
                begin
                    ok          = 1'b1;
                    do_count    = 1'b1;
                    phase_next  = PH_CLOSED;
                    closer_next = dir_reg;
                end
            end
            PH_DATA:
            begin
                if (f == FLAG_ACK)
                begin
                    ok         = 1'b1;
                    do_count   = 1'b1;
                    phase_next = PH_DATA;
                end
                else if (is_fin)
                begin
                    ok          = 1'b1;
                    do_count    = 1'b1;
                    phase_next  = PH_CLOSING;
                    closer_next = dir_reg;
                end
                else if (is_rst)
                begin
                    ok          = 1'b1;
                    do_count    = 1'b1;
                    phase_next  = PH_CLOSED;
                    closer_next = dir_reg;
                end
            end
            PH_CLOSING:
            begin
                if (f == FLAG_ACK)
                begin
                    ok         = 1'b1;
                    do_count   = 1'b1;
                    phase_next = PH_CLOSING;
                end
                else if (is_fin)
                begin
                    // A repeated FIN from the closing side changes nothing.
                    ok = 1'b1;
                    if (dir_reg != closer_reg)
                    begin
                        do_count   = 1'b1;
                        phase_next = PH_CLOSED;
                    end
                    else
                    begin
                        phase_next = PH_CLOSING;
                    end
                end
                else if (is_rst)
                begin
                    ok         = 1'b1;
                    do_count   = 1'b1;
                    phase_next = PH_CLOSED;
                end
            end
            PH_CLOSED:
            begin
                if (f == FLAG_ACK || is_fin || is_rst)
                begin
                    ok         = 1'b1;
                    do_count   = 1'b1;
                    phase_next = PH_CLOSED;
                end
            end
            default:
            begin
                phase_next = PH_FAIL;
            end
        endcase
    end

    // Byte counter and timestamp update; one shared 64-bit adder.
    assign cnt_sel = dir_reg ? cnt1_reg : cnt0_reg;
    assign cnt_sum = cnt_sel + {48'd0, size_reg};

    always_comb
    begin
        opener_next = opener_reg;
        cnt0_next   = cnt0_reg;
        cnt1_next   = cnt1_reg;
        last_next   = last_reg;
        if (do_open)
        begin
            opener_next = dir_reg;
            cnt0_next   = 64'd0;
            cnt1_next   = 64'd0;
            last_next   = now_reg;
        end
        else if (do_count)
        begin
            if (dir_reg)
            begin
                cnt1_next = cnt_sum;
            end
            else
            begin
                cnt0_next = cnt_sum;
            end
            last_next = now_reg;
        end
    end

    // Connection state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LISTEN;
            opener_reg <= 1'b0;
            closer_reg <= 1'b0;
            cnt0_reg   <= 64'd0;
            cnt1_reg   <= 64'd0;
            last_reg   <= 64'd0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            opener_reg <= opener_next;
            closer_reg <= closer_next;
            cnt0_reg   <= cnt0_next;
            cnt1_reg   <= cnt1_next;
            last_reg   <= last_next;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_ok_reg    <= ok;
            res_state_reg <= phase_next;
            res_cnt0_reg  <= cnt0_next;
            res_cnt1_reg  <= cnt1_next;
            res_last_reg  <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign accepted   = res_ok_reg;
    assign conn_state = res_state_reg;
    assign bytes_dir0 = res_cnt0_reg;
    assign bytes_dir1 = res_cnt1_reg;
    assign last_time  = res_last_reg;

endmodule

`default_nettype wire

/* bench/tcp_connection_tracker_unit_checker.sv */
// Checker for the TCP connection tracker: predicts each result and compares the result channel.
module tcp_connection_tracker_unit_checker
    import tcpct_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        pkt_dir,
    input  wire logic [7:0]  tcp_flags,
    input  wire logic [15:0] seg_size,
    input  wire logic [63:0] time_now,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        accepted,
    input  wire logic [2:0]  conn_state,
    input  wire logic [63:0] bytes_dir0,
    input  wire logic [63:0] bytes_dir1,
    input  wire logic [63:0] last_time,
    output int               error_count,
    output int               results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    // One expected result of the tracker.
    typedef struct packed {
        logic        accepted;
        phase_t      conn_state;
        logic [63:0] bytes0;
        logic [63:0] bytes1;
        logic [63:0] last_time;
    } tracker_result_t;

    // Expected results in request order.
    tracker_result_t results_due[$];
    tracker_result_t want;

    // Shadow copy of the connection state.
    phase_t      phase = PH_LISTEN;
    logic        opener_side = 1'b0;
    logic        closer_side = 1'b0;
    logic [63:0] byte_count [2];
    logic [63:0] last_seen = '0;
    logic [63:0] first_seen = '0;

    initial begin
        byte_count[0] = '0;
        byte_count[1] = '0;
    end

    function automatic logic is_reset_seg(input logic [7:0] f);
        return f == FLAG_RST || f == F_RSTACK;
    endfunction

    function automatic logic is_fin_seg(input logic [7:0] f);
        return f == FLAG_FIN || f == F_FINACK;
    endfunction

    // A counted segment adds its size to its direction and moves the last time.
    function automatic void count_bytes(input logic dir, input logic [15:0] size,
                                        input logic [63:0] stamp);
        byte_count[dir] = byte_count[dir] + 64'(size);
        last_seen = stamp;
    endfunction

    // Advance the shadow connection by one segment and return the result it yields.
    function automatic tracker_result_t track_segment(input logic dir, input logic [7:0] raw,
                                                      input logic [15:0] size,
                                                      input logic [63:0] stamp);
        logic [7:0]      f;
        logic            fits;
        logic            from_opener;
        tracker_result_t r;
        f = raw & FLAG_TRACKED;
        from_opener = (dir == opener_side);
        fits = 1'b0;
        case (phase)
            PH_LISTEN: begin
                if (f == FLAG_SYN) begin
                    phase = PH_REQ;
                    opener_side = dir;
                    byte_count[0] = '0;
                    byte_count[1] = '0;
                    first_seen = stamp;
                    last_seen = stamp;
                    fits = 1'b1;
                end
            end
            PH_REQ: begin
                if (f == F_SYNACK) begin
                    if (!from_opener) begin
                        phase = PH_EST;
                        count_bytes(dir, size, stamp);
                        fits = 1'b1;
                    end
                end else if (f == FLAG_SYN || f == FLAG_ACK) begin
                    fits = from_opener;
                end else if (is_reset_seg(f)) begin
                    phase = PH_CLOSED;
                    closer_side = dir;
                    count_bytes(dir, size, stamp);
                    fits = 1'b1;
                end
            end
            PH_EST: begin
                if (f == FLAG_ACK) begin
                    if (from_opener) begin
                        phase = PH_DATA;
                        count_bytes(dir, size, stamp);
                        fits = 1'b1;
                    end
                end else if (f == FLAG_SYN) begin
                    fits = from_opener;
                end else if (f == F_SYNACK) begin
                    fits = !from_opener;
                end else if (is_reset_seg(f)) begin
                    phase = PH_CLOSED;
                    closer_side = dir;
                    count_bytes(dir, size, stamp);
                    fits = 1'b1;
                end
            end
            PH_DATA: begin
                if (f == FLAG_ACK) begin
                    count_bytes(dir, size, stamp);
                    fits = 1'b1;
                end else if (is_fin_seg(f)) begin
                    phase = PH_CLOSING;
                    closer_side = dir;
                    count_bytes(dir, size, stamp);
                    fits = 1'b1;
                end else if (is_reset_seg(f)) begin
                    phase = PH_CLOSED;
                    closer_side = dir;
                    count_bytes(dir, size, stamp);
                    fits = 1'b1;
                end
            end
            PH_CLOSING: begin
                if (f == FLAG_ACK) begin
                    count_bytes(dir, size, stamp);
                    fits = 1'b1;
                end else if (is_fin_seg(f)) begin
                    // A repeated FIN from the side that began the close changes nothing.
                    if (dir != closer_side) begin
                        phase = PH_CLOSED;
                        count_bytes(dir, size, stamp);
                    end
                    fits = 1'b1;
                end else if (is_reset_seg(f)) begin
                    phase = PH_CLOSED;
                    count_bytes(dir, size, stamp);
                    fits = 1'b1;
                end
            end
            PH_CLOSED: begin
                if (f == FLAG_ACK || is_fin_seg(f) || is_reset_seg(f)) begin
                    count_bytes(dir, size, stamp);
                    fits = 1'b1;
                end
            end
            default: begin
            end
        endcase
        // Anything that does not fit the connection lands in the sticky failure phase.
        if (!fits) begin
            phase = PH_FAIL;
        end
        r.accepted = fits;
        r.conn_state = phase;
        r.bytes0 = byte_count[0];
        r.bytes1 = byte_count[1];
        r.last_time = last_seen;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_val,
                                 input logic [63:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, got_val);
            error_count++;
        end
    endtask

    // Score results first, then record the request taken at the same edge.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase = PH_LISTEN;
            opener_side = 1'b0;
            closer_side = 1'b0;
            byte_count[0] = '0;
            byte_count[1] = '0;
            last_seen = '0;
            first_seen = '0;
            results_due.delete();
            error_count = 0;
            results_owed = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result with no request outstanding: state %0d", conn_state);
                    error_count++;
                end else begin
                    want = results_due.pop_front();
                    compare_field("accepted", 64'(want.accepted), 64'(accepted));
                    compare_field("conn_state", 64'(want.conn_state), 64'(conn_state));
                    compare_field("bytes_dir0", want.bytes0, bytes_dir0);
                    compare_field("bytes_dir1", want.bytes1, bytes_dir1);
                    compare_field("last_time", want.last_time, last_time);
                end
            end
            if (in_valid && in_ready) begin
                results_due.push_back(track_segment(pkt_dir, tcp_flags, seg_size, time_now));
            end
            results_owed = results_due.size();
        end
    end

endmodule

/* bench/tcp_connection_tracker_unit_tb.sv */
// Testbench top for the TCP connection tracker: clock, reset, requests, receiver and verdict.
module tcp_connection_tracker_unit_tb;
    import tcpct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RUN_LENGTH     = 420;
    localparam int CLOSED_ITEMS   = 40;
    localparam int NOISE_ITEMS    = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        pkt_dir;
    logic [7:0]  tcp_flags;
    logic [15:0] seg_size;
    logic [63:0] time_now;
    logic        out_valid;
    logic        out_ready;
    logic        accepted;
    logic [2:0]  conn_state;
    logic [63:0] bytes_dir0;
    logic [63:0] bytes_dir1;
    logic [63:0] last_time;

    int mismatches;
    int owed;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_results = 1'b0;

    tcp_connection_tracker_unit dut (.*);

    tcp_connection_tracker_unit_checker scoreboard (
        .error_count (mismatches),
        .results_owed(owed),
        .*
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off when the request side asks for it.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_results) begin
                hold_results = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles where neither channel moves anything.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Set flag bits that the tracker ignores at random.
    function automatic logic [7:0] with_noise(input logic [7:0] f);
        return f | (8'($urandom) & ~FLAG_TRACKED);
    endfunction

    function automatic logic [15:0] rand_size();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_stamp();
        case ($urandom_range(7))
            0:       return 64'h0;
            1:       return '1;
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Offer one segment request, hold it until taken, then idle per the current mode.
    task automatic offer_segment(input logic dir, input logic [7:0] flags,
                                 input logic [15:0] size, input logic [63:0] stamp);
        int gap;
        in_valid <= 1'b1;
        pkt_dir <= dir;
        tcp_flags <= flags;
        seg_size <= size;
        time_now <= stamp;
        do @(posedge clk); while (!in_ready);
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial begin
        logic       closer;
        logic [7:0] closed_flags;
        rst_n = 1'b0;
        in_valid = 1'b0;
        pkt_dir = 1'b0;
        tcp_flags = 8'h00;
        seg_size = 16'h0000;
        time_now = 64'h0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Handshake opened by side 1, with retransmissions and ignored flag bits.
        offer_segment(1'b1, FLAG_SYN | ~FLAG_TRACKED, 16'hFFFF, '1);
        offer_segment(1'b1, FLAG_SYN, 16'd100, 64'd1);
        offer_segment(1'b1, FLAG_ACK, 16'hFFFF, 64'd2);
        offer_segment(1'b0, F_SYNACK, 16'hFFFF, 64'h0);
        offer_segment(1'b1, FLAG_SYN, 16'd7, 64'd3);
        offer_segment(1'b0, F_SYNACK | ~FLAG_TRACKED, 16'd9, 64'd4);
        offer_segment(1'b1, FLAG_ACK, 16'h0000, 64'h8000_0000_0000_0000);

        // Data transfer extremes.
        offer_segment(1'b0, FLAG_ACK | ~FLAG_TRACKED, 16'hFFFF, '1);
        offer_segment(1'b1, FLAG_ACK, 16'hFFFF, 64'h0);
        offer_segment(1'b1, FLAG_ACK, 16'h0001, 64'h5555_AAAA_5555_AAAA);

        // Random data transfer under each idling mode; the first mode also fills the block.
        for (int m = 0; m < 4; m++) begin
            case (m)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_results = 1'b1;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 63;
                end
                default: begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                end
            endcase
            repeat (RUN_LENGTH) begin
                offer_segment(1'($urandom_range(1)), with_noise(FLAG_ACK), rand_size(),
                              rand_stamp());
            end
        end

        // Close started by a random side; a repeated FIN from that side changes nothing.
        closer = 1'($urandom_range(1));
        offer_segment(closer, with_noise($urandom_range(1) ? F_FINACK : FLAG_FIN),
                      rand_size(), rand_stamp());
        repeat (4) begin
            offer_segment(1'($urandom_range(1)), with_noise(FLAG_ACK), rand_size(),
                          rand_stamp());
        end
        offer_segment(closer, with_noise(FLAG_FIN), rand_size(), rand_stamp());
        offer_segment(closer, with_noise(F_FINACK), rand_size(), rand_stamp());
        offer_segment(!closer, with_noise(FLAG_ACK), rand_size(), rand_stamp());

        // Finish the close by the peer's FIN or by a reset from either side.
        if ($urandom_range(1) == 1) begin
            offer_segment(!closer, with_noise($urandom_range(1) ? F_FINACK : FLAG_FIN),
                          rand_size(), rand_stamp());
        end else begin
            offer_segment(1'($urandom_range(1)),
                          with_noise($urandom_range(1) ? F_RSTACK : FLAG_RST),
                          rand_size(), rand_stamp());
        end

        // Late segments after the close are still counted.
        for (int i = 0; i < CLOSED_ITEMS; i++) begin
            case ($urandom_range(4))
                0:       closed_flags = FLAG_ACK;
                1:       closed_flags = FLAG_FIN;
                2:       closed_flags = F_FINACK;
                3:       closed_flags = FLAG_RST;
                default: closed_flags = F_RSTACK;
            endcase
            offer_segment(1'($urandom_range(1)), with_noise(closed_flags), rand_size(),
                          rand_stamp());
        end

        // An unexpected SYN breaks the connection; everything after it is rejected.
        offer_segment(1'($urandom_range(1)), FLAG_SYN, rand_size(), rand_stamp());
        repeat (NOISE_ITEMS) begin
            offer_segment(1'($urandom_range(1)), 8'($urandom), rand_size(), rand_stamp());
        end

        // Drain the outstanding results, then give the verdict.
        in_valid <= 1'b0;
        do @(negedge clk); while (owed != 0);
        repeat (10) @(negedge clk);
        if (mismatches == 0 && owed == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* tcp_connection_tracker_unit.f */
src/tcpct_pkg.sv
src/tcp_connection_tracker_unit.sv
bench/tcp_connection_tracker_unit_checker.sv
bench/tcp_connection_tracker_unit_tb.sv
